// ----- hdl/kfc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants of the keyed FIFO with cancel
// Built depth, key width, command and response beats, per-cell control.
// ----------------------------------------------------------------------------
package kfc_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CAP_W    = 5;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_CANCEL  = 2'd1,
        KIND_SERVE   = 2'd2,
        KIND_STATUS  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        kind_t kind;
        key_t  key;
    } cmd_t;

    typedef struct packed {
        status_t status;
        key_t    served_key;
        cnt_t    occupancy;
        cnt_t    free_slots;
    } rsp_t;

    typedef struct packed {
        logic valid;
        logic load;
        logic cancel;
        logic serve;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/keyed_fifo_with_cancel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_fifo_with_cancel: bounded FIFO of keys with cancel by key
// Commands arrive on cmd (cmd_valid/cmd_stall): enqueue, cancel the oldest
// matching key, serve the head, or query status. Each command produces
// exactly one response beat on rsp (rsp_valid/rsp_stall) carrying the status,
// the served key (zero unless a serve succeeded), and the occupancy and
// free slots after the command.
// The queue is a row of slot cells; all cells compare against the command
// key in parallel and shift toward the head in the same cycle, so a command
// is answered in the cycle after it is accepted and one command is taken
// every cycle. The response register decouples the two sides: a new command
// is accepted while a response waits, as long as that response is taken in
// the same cycle; while rsp_stall holds a pending response, cmd_stall is
// high. The user must write the capacity register on cfg (cfg_valid/cfg_ready,
// always ready) only while the block is idle (not enforced). Values above
// the built depth act as the depth. Reset empties the queue, clears rsp_valid
// and sets the capacity to 16. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module keyed_fifo_with_cancel (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire kfc_pkg::cmd_t                  cmd,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output kfc_pkg::rsp_t                       rsp,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kfc_pkg::CAP_W-1:0]      cfg_data
);

    logic [kfc_pkg::CAP_W-1:0] capacity_reg;
    logic [kfc_pkg::CAP_W-1:0] capacity_next;
    kfc_pkg::cnt_t             count_reg;
    kfc_pkg::cnt_t             count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    kfc_pkg::rsp_t             rsp_reg;
    kfc_pkg::rsp_t             rsp_next;

    kfc_pkg::cell_ctrl_t       ctrl [kfc_pkg::DEPTH];
    kfc_pkg::key_t             entry_w [kfc_pkg::DEPTH+1];
    logic                      found_w [kfc_pkg::DEPTH+1];

    kfc_pkg::cnt_t             cap_use;
    logic                      accept;
    logic                      is_enq;
    logic                      is_cancel;
    logic                      is_serve;
    logic                      enq_ok;
    logic                      serve_ok;
    logic                      found;

    assign cfg_ready = 1'b1;
    assign cmd_stall = rsp_valid_reg & rsp_stall;
    assign accept    = cmd_valid & ~cmd_stall;

    always_comb
    begin
        if ({{(kfc_pkg::CNT_W){1'b0}}, capacity_reg} > (kfc_pkg::CNT_W + kfc_pkg::CAP_W)'(kfc_pkg::DEPTH))
        begin
            cap_use = kfc_pkg::CNT_W'(kfc_pkg::DEPTH);
        end
        else
        begin
            cap_use = kfc_pkg::CNT_W'(capacity_reg);
        end
    end

    assign is_enq    = (cmd.kind == kfc_pkg::KIND_ENQUEUE);
    assign is_cancel = (cmd.kind == kfc_pkg::KIND_CANCEL);
    assign is_serve  = (cmd.kind == kfc_pkg::KIND_SERVE);
    assign enq_ok    = is_enq & (count_reg < cap_use);
    assign serve_ok  = is_serve & (count_reg != '0);

    assign found_w[0]                  = 1'b0;
    assign entry_w[kfc_pkg::DEPTH]     = '0;
    assign found                       = found_w[kfc_pkg::DEPTH];

    for (genvar i = 0; i < kfc_pkg::DEPTH; i++)
    begin : g_cell
        assign ctrl[i].valid  = (kfc_pkg::CNT_W'(i) < count_reg);
        assign ctrl[i].load   = accept & enq_ok & (kfc_pkg::CNT_W'(i) == count_reg);
        assign ctrl[i].cancel = accept & is_cancel;
        assign ctrl[i].serve  = accept & serve_ok;

        kfc_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .key        (cmd.key),
            .next_entry (entry_w[i+1]),
            .found_in   (found_w[i]),
            .entry      (entry_w[i]),
            .found_out  (found_w[i+1])
        );
    end

    always_comb
    begin
        count_next          = count_reg;
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg & rsp_stall;
        if (accept)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.status     = kfc_pkg::ST_OK;
            rsp_next.served_key = '0;
            case (cmd.kind)
                kfc_pkg::KIND_ENQUEUE:
                begin
                    if (enq_ok)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = kfc_pkg::ST_FULL;
                    end
                end
                kfc_pkg::KIND_CANCEL:
                begin
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = kfc_pkg::ST_NOT_FOUND;
                    end
                end
                kfc_pkg::KIND_SERVE:
                begin
                    if (serve_ok)
                    begin
                        count_next          = count_reg - 1'b1;
                        rsp_next.served_key = entry_w[0];
                    end
                    else
                    begin
                        rsp_next.status = kfc_pkg::ST_EMPTY;
                    end
                end
                kfc_pkg::KIND_STATUS:
                begin
                    count_next = count_reg;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            rsp_next.occupancy  = count_next;
            rsp_next.free_slots = (cap_use > count_next) ? (cap_use - count_next) : '0;
        end
    end

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_valid & cfg_ready)
        begin
            capacity_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= kfc_pkg::CAP_W'(16);
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// ----- hdl/kfc_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kfc_cell: one queue slot
// Holds one key, compares it with the command key, and either keeps it,
// loads the command key, or takes the key of its tail-side neighbor.
// ----------------------------------------------------------------------------
module kfc_cell (
    input  wire logic                clk,
    input  wire kfc_pkg::cell_ctrl_t ctrl,
    input  wire kfc_pkg::key_t       key,
    input  wire kfc_pkg::key_t       next_entry,
    input  wire logic                found_in,
    output kfc_pkg::key_t            entry,
    output logic                     found_out
);

    kfc_pkg::key_t entry_reg;
    kfc_pkg::key_t entry_next;
    logic          match;
    logic          shift;

    assign match     = ctrl.valid && (entry_reg == key);
    assign found_out = found_in | match;
    assign shift     = ctrl.serve | (ctrl.cancel & found_out);

    always_comb
    begin
        if (shift)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.load)
        begin
            entry_next = key;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

// ----- hdl/kfc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kfc_checker: port-level checks of the keyed FIFO with cancel
// Watches the command, response and configuration ports over time.
// ----------------------------------------------------------------------------
module kfc_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      cmd_valid,
    input wire logic                      cmd_stall,
    input wire kfc_pkg::cmd_t             cmd,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_stall,
    input wire kfc_pkg::rsp_t             rsp,
    input wire logic                      cfg_valid,
    input wire logic                      cfg_ready,
    input wire logic [kfc_pkg::CAP_W-1:0] cfg_data
);

    // A response that is held back keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // Every accepted command yields a response beat in the next cycle.
    a_cmd_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> rsp_valid)
        else $error("accepted command produced no response");

    // Commands are held off only by a pending response.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("command stalled without a held response");

    // A response with a status other than ok carries a zero key.
    a_served_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != kfc_pkg::ST_OK |-> rsp.served_key == '0)
        else $error("failed command returned a key");

    // Occupancy and free slots never exceed the built depth.
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.occupancy <= kfc_pkg::CNT_W'(kfc_pkg::DEPTH)
            && rsp.free_slots <= kfc_pkg::CNT_W'(kfc_pkg::DEPTH))
        else $error("occupancy or free slots out of range");

endmodule

bind keyed_fifo_with_cancel kfc_checker u_kfc_checker (.*);
`default_nettype wire

// ----- dv/kfc_checker.sv -----
// ----------------------------------------------------------------------------
// kfc_scoreboard: response checker for the keyed FIFO with cancel
// Watches the command, response and capacity channels. Every accepted command
// beat is applied to a local copy of the queue and the capacity, and the
// response it should produce is stored. Every accepted response beat is
// compared field by field with the oldest stored response.
// ----------------------------------------------------------------------------
module kfc_scoreboard (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cmd_valid,
    input  wire logic                      cmd_stall,
    input  wire kfc_pkg::cmd_t             cmd,
    input  wire logic                      rsp_valid,
    input  wire logic                      rsp_stall,
    input  wire kfc_pkg::rsp_t             rsp,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [kfc_pkg::CAP_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);

    kfc_pkg::key_t             queued_keys[$];
    kfc_pkg::rsp_t             expected_rsp[$];
    logic [kfc_pkg::CAP_W-1:0] capacity;
    kfc_pkg::rsp_t             want;
    int                        fail_count;

    function automatic kfc_pkg::rsp_t apply_command(kfc_pkg::cmd_t c);
        kfc_pkg::rsp_t r;
        int            slots;
        int            hit;
        r.status     = kfc_pkg::ST_OK;
        r.served_key = '0;
        slots        = (capacity > kfc_pkg::DEPTH) ? kfc_pkg::DEPTH : int'(capacity);
        hit          = -1;
        case (c.kind)
            kfc_pkg::KIND_ENQUEUE:
            begin
                if (queued_keys.size() >= slots)
                    r.status = kfc_pkg::ST_FULL;
                else
                    queued_keys.push_back(c.key);
            end
            kfc_pkg::KIND_CANCEL:
            begin
                foreach (queued_keys[i])
                    if (hit < 0 && queued_keys[i] == c.key)
                        hit = i;
                if (hit < 0)
                    r.status = kfc_pkg::ST_NOT_FOUND;
                else
                    queued_keys.delete(hit);
            end
            kfc_pkg::KIND_SERVE:
            begin
                if (queued_keys.size() == 0)
                    r.status = kfc_pkg::ST_EMPTY;
                else
                    r.served_key = queued_keys.pop_front();
            end
            kfc_pkg::KIND_STATUS:
            begin
            end
            default:
            begin
            end
        endcase
        r.occupancy  = kfc_pkg::cnt_t'(queued_keys.size());
        r.free_slots = kfc_pkg::cnt_t'(slots > queued_keys.size() ?
                                       slots - queued_keys.size() : 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_keys.delete();
            expected_rsp.delete();
            capacity    = kfc_pkg::CAP_W'(16);
            fail_count  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"unexpected response beat: expected none, got status %0d ",
                                  "key %h occupancy %0d free %0d"},
                                 rsp.status, rsp.served_key, rsp.occupancy,
                                 rsp.free_slots);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.served_key !== want.served_key ||
                        rsp.occupancy !== want.occupancy || rsp.free_slots !== want.free_slots)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"response mismatch: expected status %0d key %h ",
                                      "occupancy %0d free %0d, got status %0d key %h ",
                                      "occupancy %0d free %0d"},
                                     want.status, want.served_key, want.occupancy,
                                     want.free_slots, rsp.status, rsp.served_key,
                                     rsp.occupancy, rsp.free_slots);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (cmd_valid && !cmd_stall)
                expected_rsp.push_back(apply_command(cmd));
            mismatches  <= fail_count;
            outstanding <= expected_rsp.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top for the keyed FIFO with cancel
// Drives a directed sequence covering empty, full, duplicate keys, absent
// keys and capacity corner values, then random command phases under several
// capacities and idle and stall patterns. Checking is done by kfc_scoreboard.
// ----------------------------------------------------------------------------
module tb;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cmd_valid;
    logic                      cmd_stall;
    kfc_pkg::cmd_t             cmd;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    kfc_pkg::rsp_t             rsp;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [kfc_pkg::CAP_W-1:0] cfg_data;
    int                        mismatches;
    int                        outstanding;
    int                        idle_pct  = 0;
    int                        stall_pct = 0;
    kfc_pkg::key_t             key_pool[8];

    always #5 clk = ~clk;

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    keyed_fifo_with_cancel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    kfc_scoreboard scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_cmd(input kfc_pkg::kind_t k, input kfc_pkg::key_t key);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= {k, key};
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic drain_queue();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [kfc_pkg::CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [kfc_pkg::CAP_W-1:0] phase_cap[8];
        int                        pick;
        kfc_pkg::kind_t            k;
        kfc_pkg::key_t             key;
        int                        n;

        phase_cap = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd17, 5'd1, 5'd9};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < 8; n++)
            key_pool[n] = $urandom;

        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity(5'd16);
        send_cmd(kfc_pkg::KIND_SERVE, '0);
        send_cmd(kfc_pkg::KIND_CANCEL, '0);
        send_cmd(kfc_pkg::KIND_STATUS, '1);
        send_cmd(kfc_pkg::KIND_ENQUEUE, '0);
        send_cmd(kfc_pkg::KIND_ENQUEUE, '1);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[2]);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[2]);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[3]);
        send_cmd(kfc_pkg::KIND_CANCEL, key_pool[2]);
        send_cmd(kfc_pkg::KIND_CANCEL, 32'h5a5a_5a5a);
        send_cmd(kfc_pkg::KIND_CANCEL, '1);
        send_cmd(kfc_pkg::KIND_STATUS, '0);
        send_cmd(kfc_pkg::KIND_SERVE, '0);
        send_cmd(kfc_pkg::KIND_SERVE, '0);
        send_cmd(kfc_pkg::KIND_SERVE, '0);
        send_cmd(kfc_pkg::KIND_SERVE, '0);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[4]);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[5]);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[6]);
        drain_queue();
        write_capacity(5'd1);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[7]);
        send_cmd(kfc_pkg::KIND_STATUS, '0);
        drain_queue();
        write_capacity(5'd0);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[7]);
        send_cmd(kfc_pkg::KIND_SERVE, '0);
        drain_queue();
        write_capacity(5'd31);
        send_cmd(kfc_pkg::KIND_ENQUEUE, key_pool[3]);
        send_cmd(kfc_pkg::KIND_ENQUEUE, 32'h8000_0001);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain_queue();
            write_capacity(phase_cap[phase]);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            for (int i = 0; i < 85; i++)
            begin
                if (i == 40)
                    drain_queue();
                pick = $urandom_range(99);
                k    = (pick < 38) ? kfc_pkg::KIND_ENQUEUE :
                       (pick < 62) ? kfc_pkg::KIND_CANCEL  :
                       (pick < 88) ? kfc_pkg::KIND_SERVE   : kfc_pkg::KIND_STATUS;
                key  = ($urandom_range(4) == 0) ? kfc_pkg::key_t'($urandom) :
                                                  key_pool[$urandom_range(7)];
                send_cmd(k, key);
            end
        end

        cmd_valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        for (n = 0; n < 2000 && outstanding != 0; n++)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/kfc_pkg.sv
hdl/kfc_cell.sv
hdl/keyed_fifo_with_cancel.sv
hdl/kfc_checker.sv
dv/kfc_checker.sv
dv/tb.sv
